[hdl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Types, constants and helpers shared by the series statistics block.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned FRAC_BITS   = 8;
    localparam int unsigned MAX_SAMPLES = 1048576;
    localparam int unsigned COUNT_BITS  = 21;
    localparam int unsigned POS_BITS    = 20;
    localparam int unsigned SUM_BITS    = 36;
    localparam int unsigned SUMSQ_BITS  = 52;
    localparam int unsigned BW_BITS     = 24;
    localparam int unsigned WIDE_BITS   = 128;
    localparam int unsigned STEP_BITS   = 7;
    localparam logic [BW_BITS-1:0] BW_RESET = 24'd14000;
    localparam logic [6:0] UTIL_SCALE = 7'd100;

    typedef logic [WIDE_BITS-1:0] wide_t;

    typedef enum logic [1:0]
    {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } op_t;

    typedef struct packed
    {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } in_item_t;

    typedef struct packed
    {
        logic [20:0] sample_count;
        logic [15:0] min_value;
        logic [19:0] min_index;
        logic [15:0] max_value;
        logic [19:0] max_index;
        logic [35:0] total;
        logic [23:0] mean;
        logic [47:0] variance;
        logic [23:0] std_dev;
        logic [31:0] coeff_variation;
        logic [24:0] high_estimate;
        logic [23:0] high_util_percent;
    } out_item_t;

    // saturate a wide value to w bits, w below 64
    function automatic logic [63:0] sat_w(wide_t v, int unsigned w);
        logic [63:0] mask;
        mask = (64'd1 << w) - 64'd1;
        if ((v >> w) != '0)
            return mask;
        return v[63:0];
    endfunction

endpackage

[hdl/sss_unit.sv]
// ----------------------------------------------------------------------------
// sss_unit
// Shared iterative unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module sss_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sss_pkg::op_t       op,
    input  sss_pkg::wide_t     a,
    input  sss_pkg::wide_t     b,
    output logic               done,
    output sss_pkg::wide_t     result
);

    localparam sss_pkg::wide_t SQRT_BIT_INIT = sss_pkg::wide_t'(1) << (sss_pkg::WIDE_BITS - 2);
    localparam logic [sss_pkg::STEP_BITS-1:0] LONG_STEPS = '1;
    localparam logic [sss_pkg::STEP_BITS-1:0] SQRT_STEPS = 7'(sss_pkg::WIDE_BITS / 2 - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [sss_pkg::STEP_BITS-1:0]   cnt_reg, cnt_next;
    sss_pkg::op_t                    op_reg;
    sss_pkg::wide_t                  x_reg, x_next;
    sss_pkg::wide_t                  y_reg, y_next;
    sss_pkg::wide_t                  acc_reg, acc_next;
    sss_pkg::wide_t                  rem;
    sss_pkg::wide_t                  trial;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        rem      = {acc_reg[sss_pkg::WIDE_BITS-2:0], x_reg[sss_pkg::WIDE_BITS-1]};
        trial    = acc_reg + y_reg;
        unique case (op_reg)
            sss_pkg::OP_MUL:
            begin
                if (y_reg[0])
                    acc_next = acc_reg + x_reg;
                x_next = x_reg << 1;
                y_next = y_reg >> 1;
            end
            sss_pkg::OP_DIV:
            begin
                x_next = x_reg << 1;
                if (rem >= y_reg)
                begin
                    acc_next  = rem - y_reg;
                    x_next[0] = 1'b1;
                end
                else
                    acc_next = rem;
            end
            sss_pkg::OP_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    acc_next = (acc_reg >> 1) + y_reg;
                end
                else
                    acc_next = acc_reg >> 1;
                y_next = y_reg >> 2;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = (op == sss_pkg::OP_SQRT) ? SQRT_STEPS : LONG_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= sss_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            if (start)
                op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= a;
            y_reg   <= (op == sss_pkg::OP_SQRT) ? SQRT_BIT_INIT : b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == sss_pkg::OP_DIV) ? x_reg : acc_reg;

endmodule

[hdl/series_summary_statistics_top.sv]
// ----------------------------------------------------------------------------
// series_summary_statistics_top
// Running count, min, max, sum and sum of squares with closing statistics.
// ----------------------------------------------------------------------------
// Sample transfers are taken only while the block is idle; in_stall is high in every other state.
// The transfer that carries last starts the closing sequence on one shared
// multiply/divide/square-root unit: three 128-step multiplies, up to five
// 128-step divides and up to two 64-step square roots, during which in_stall
// is high. The result sits in an output register, so the next series can start
// while it waits to be taken.
module series_summary_statistics_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sss_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sss_pkg::out_item_t            out_data,
    input  logic                          cfg_wen,
    input  logic [sss_pkg::BW_BITS-1:0]   cfg_wdata
);

    typedef enum logic [13:0]
    {
        ST_IDLE    = 14'b00000000000001,
        ST_MUL_NQ  = 14'b00000000000010,
        ST_MUL_SS  = 14'b00000000000100,
        ST_DIFF    = 14'b00000000001000,
        ST_MUL_NN  = 14'b00000000010000,
        ST_MEAN    = 14'b00000000100000,
        ST_VAR     = 14'b00000001000000,
        ST_SQRT_SD = 14'b00000010000000,
        ST_DIV_SD  = 14'b00000100000000,
        ST_SQRT_CV = 14'b00001000000000,
        ST_DIV_CV  = 14'b00010000000000,
        ST_HIGH    = 14'b00100000000000,
        ST_UTIL    = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

    localparam logic [31:0] UTIL_MUL = 32'(sss_pkg::UTIL_SCALE);

    state_t                                 state_reg, state_next;
    logic                                   issued_reg, issued_next;
    logic [sss_pkg::BW_BITS-1:0]            bw_reg;
    logic [sss_pkg::COUNT_BITS-1:0]         count_reg;
    logic [sss_pkg::SAMPLE_BITS-1:0]        min_reg, max_reg;
    logic [sss_pkg::POS_BITS-1:0]           min_pos_reg, max_pos_reg;
    logic [sss_pkg::SUM_BITS-1:0]           sum_reg;
    logic [sss_pkg::SUMSQ_BITS-1:0]         sumsq_reg;
    sss_pkg::wide_t                         prod_reg, t_reg, d_reg, nsq_reg;
    logic [23:0]                            mean_reg, std_reg, util_reg;
    logic [47:0]                            var_reg;
    logic [31:0]                            cv_reg;
    logic [24:0]                            high_reg;
    logic                                   out_valid_reg;
    sss_pkg::out_item_t                     out_reg;

    logic                                   in_take;
    logic                                   out_free;
    logic                                   unit_start, unit_done;
    sss_pkg::op_t                           unit_op;
    sss_pkg::wide_t                         unit_a, unit_b, unit_res;
    logic                                   is_op_state;
    logic                                   skip_cv, skip_util;
    logic [25:0]                            high_sum;
    logic [sss_pkg::SAMPLE_BITS*2-1:0]      sq;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign skip_cv   = (sum_reg == '0);
    assign skip_util = (bw_reg == '0);
    assign high_sum  = {2'b00, mean_reg} + {1'b0, std_reg, 1'b0};
    assign sq        = in_data.sample * in_data.sample;

    // operand selection for the shared unit
    always_comb
    begin
        unit_op     = sss_pkg::OP_MUL;
        unit_a      = '0;
        unit_b      = '0;
        is_op_state = 1'b1;
        unique case (state_reg)
            ST_MUL_NQ:
            begin
                unit_a = sss_pkg::wide_t'(count_reg);
                unit_b = sss_pkg::wide_t'(sumsq_reg);
            end
            ST_MUL_SS:
            begin
                unit_a = sss_pkg::wide_t'(sum_reg);
                unit_b = sss_pkg::wide_t'(sum_reg);
            end
            ST_MUL_NN:
            begin
                unit_a = sss_pkg::wide_t'(count_reg);
                unit_b = sss_pkg::wide_t'(count_reg);
            end
            ST_MEAN:
            begin
                unit_op = sss_pkg::OP_DIV;
                unit_a  = sss_pkg::wide_t'(sum_reg) << sss_pkg::FRAC_BITS;
                unit_b  = sss_pkg::wide_t'(count_reg);
            end
            ST_VAR:
            begin
                unit_op = sss_pkg::OP_DIV;
                unit_a  = d_reg << sss_pkg::FRAC_BITS;
                unit_b  = nsq_reg;
            end
            ST_SQRT_SD:
            begin
                unit_op = sss_pkg::OP_SQRT;
                unit_a  = d_reg << (2 * sss_pkg::FRAC_BITS);
            end
            ST_DIV_SD:
            begin
                unit_op = sss_pkg::OP_DIV;
                unit_a  = t_reg;
                unit_b  = sss_pkg::wide_t'(count_reg);
            end
            ST_SQRT_CV:
            begin
                unit_op = sss_pkg::OP_SQRT;
                unit_a  = d_reg << 32;
            end
            ST_DIV_CV:
            begin
                unit_op = sss_pkg::OP_DIV;
                unit_a  = t_reg;
                unit_b  = sss_pkg::wide_t'(sum_reg);
            end
            ST_UTIL:
            begin
                unit_op = sss_pkg::OP_DIV;
                unit_a  = sss_pkg::wide_t'(high_reg * UTIL_MUL);
                unit_b  = sss_pkg::wide_t'(bw_reg);
            end
            default:
            begin
                is_op_state = 1'b0;
            end
        endcase
    end

    assign unit_start = is_op_state && !issued_reg
                        && !(state_reg == ST_SQRT_CV && skip_cv)
                        && !(state_reg == ST_UTIL && skip_util);

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        if (unit_start)
            issued_next = 1'b1;
        if (unit_done)
            issued_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && in_data.last)
                    state_next = ST_MUL_NQ;
            end
            ST_MUL_NQ:  if (unit_done) state_next = ST_MUL_SS;
            ST_MUL_SS:  if (unit_done) state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_MUL_NN;
            ST_MUL_NN:  if (unit_done) state_next = ST_MEAN;
            ST_MEAN:    if (unit_done) state_next = ST_VAR;
            ST_VAR:     if (unit_done) state_next = ST_SQRT_SD;
            ST_SQRT_SD: if (unit_done) state_next = ST_DIV_SD;
            ST_DIV_SD:  if (unit_done) state_next = ST_SQRT_CV;
            ST_SQRT_CV:
            begin
                if (skip_cv)
                    state_next = ST_HIGH;
                else if (unit_done)
                    state_next = ST_DIV_CV;
            end
            ST_DIV_CV:  if (unit_done) state_next = ST_HIGH;
            ST_HIGH:    state_next = ST_UTIL;
            ST_UTIL:
            begin
                if (skip_util || unit_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    sss_unit u_unit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .op     (unit_op),
        .a      (unit_a),
        .b      (unit_b),
        .done   (unit_done),
        .result (unit_res)
    );

    // control and series accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            bw_reg        <= sss_pkg::BW_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            min_reg       <= '1;
            min_pos_reg   <= '0;
            max_reg       <= '0;
            max_pos_reg   <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            if (cfg_wen)
                bw_reg <= cfg_wdata;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (in_take && (count_reg < sss_pkg::COUNT_BITS'(sss_pkg::MAX_SAMPLES)))
            begin
                if (in_data.sample <= min_reg)
                begin
                    min_reg     <= in_data.sample;
                    min_pos_reg <= count_reg[sss_pkg::POS_BITS-1:0];
                end
                if (in_data.sample >= max_reg)
                begin
                    max_reg     <= in_data.sample;
                    max_pos_reg <= count_reg[sss_pkg::POS_BITS-1:0];
                end
                sum_reg   <= sum_reg + sss_pkg::SUM_BITS'(in_data.sample);
                sumsq_reg <= sumsq_reg + sss_pkg::SUMSQ_BITS'(sq);
                count_reg <= count_reg + 1'b1;
            end
            else if (state_reg == ST_OUT && out_free)
            begin
                count_reg     <= '0;
                min_reg       <= '1;
                min_pos_reg   <= '0;
                max_reg       <= '0;
                max_pos_reg   <= '0;
                sum_reg       <= '0;
                sumsq_reg     <= '0;
            end
        end
    end

    // closing results
    always_ff @(posedge clk)
    begin
        if (unit_done)
        begin
            unique case (state_reg)
                ST_MUL_NQ:  prod_reg <= unit_res;
                ST_MUL_SS:  t_reg    <= unit_res;
                ST_MUL_NN:  nsq_reg  <= unit_res;
                ST_MEAN:    mean_reg <= 24'(sss_pkg::sat_w(unit_res, 24));
                ST_VAR:     var_reg  <= 48'(sss_pkg::sat_w(unit_res, 48));
                ST_SQRT_SD: t_reg    <= unit_res;
                ST_DIV_SD:  std_reg  <= 24'(sss_pkg::sat_w(unit_res, 24));
                ST_SQRT_CV: t_reg    <= unit_res;
                ST_DIV_CV:  cv_reg   <= 32'(sss_pkg::sat_w(unit_res, 32));
                ST_UTIL:    util_reg <= 24'(sss_pkg::sat_w(unit_res, 24));
                default:    prod_reg <= prod_reg;
            endcase
        end
        if (state_reg == ST_DIFF)
            d_reg <= (prod_reg >= t_reg) ? (prod_reg - t_reg) : '0;
        if (state_reg == ST_SQRT_CV && skip_cv)
            cv_reg <= '1;
        if (state_reg == ST_HIGH)
            high_reg <= high_sum[25] ? '1 : high_sum[24:0];
        if (state_reg == ST_UTIL && skip_util)
            util_reg <= '1;
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg.sample_count      <= count_reg;
            out_reg.min_value         <= min_reg;
            out_reg.min_index         <= min_pos_reg;
            out_reg.max_value         <= max_reg;
            out_reg.max_index         <= max_pos_reg;
            out_reg.total             <= sum_reg;
            out_reg.mean              <= mean_reg;
            out_reg.variance          <= var_reg;
            out_reg.std_dev           <= std_reg;
            out_reg.coeff_variation   <= cv_reg;
            out_reg.high_estimate     <= high_reg;
            out_reg.high_util_percent <= util_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[hdl/sss_checker.sv]
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks on the series statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module sss_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input sss_pkg::out_item_t out_data
);

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sample_count != '0))
        else $error("result with empty series");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.min_value <= out_data.max_value))
        else $error("minimum above maximum");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.min_index} < out_data.sample_count)
                   && ({1'b0, out_data.max_index} < out_data.sample_count))
        else $error("position beyond count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled transfer changed");

endmodule

bind series_summary_statistics_top sss_checker u_sss_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
